>>> src/smbf_pkg.sv
package smbf_pkg;

  // APB register map: one 64-bit register every 8 bytes, selected by paddr[3]
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 64;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_EXTERNAL_SEED = 1'b0;
  localparam logic REG_RESEED_VALUE  = 1'b1;

  // Input item modes
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  // SplitMix64 constants
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
  localparam int          MIX_SH1    = 30;
  localparam int          MIX_SH2    = 27;
  localparam int          MIX_SH3    = 31;

  // Bytes in one full word, at the widths where it is compared
  localparam logic [63:0] WORD_BYTES64 = 64'd8;
  localparam logic [31:0] WORD_BYTES32 = 32'd8;
  localparam logic [3:0]  WORD_BYTES4  = 4'd8;

  typedef struct packed {
    logic        external_seed;
    logic [63:0] reseed_value;
  } cfg_t;

  // Which 32x32 partial product of the low 64 bits of a 64x64 product
  typedef enum logic [1:0] {
    MS_LL,
    MS_HL,
    MS_LH
  } mul_step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_M1_LL,
    S_M1_HL,
    S_M1_LH,
    S_M2_LL,
    S_M2_HL,
    S_M2_LH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      mul_en;
    mul_step_t mul_step;
    logic      mul_pass2;
    logic      emit_raw;
    logic      emit_mix;
  } cmd_t;

  typedef struct packed {
    logic productive;
    logic mix;
    logic out_free;
  } sts_t;

  // Keep the low k bytes of v (k of 8 or more keeps all)
  function automatic logic [63:0] low_bytes(input logic [63:0] v, input logic [3:0] k);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < k) begin
        res[8*i +: 8] = v[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

>>> src/smbf_if.sv
interface smbf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] length;
  logic [63:0] seed_word;

  modport source (output valid, output mode, output length, output seed_word, input ready);
  modport sink (input valid, input mode, input length, input seed_word, output ready);
endinterface

interface smbf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  logic [3:0]  valid_bytes;
  logic        seed_taken;
  logic        last;

  modport source (output valid, output data, output valid_bytes, output seed_taken,
                  output last, input ready);
  modport sink (input valid, input data, input valid_bytes, input seed_taken,
                input last, output ready);
endinterface

>>> src/smbf_regs.sv
module smbf_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smbf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [smbf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [smbf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output smbf_pkg::cfg_t                    cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[smbf_pkg::REG_SEL_BIT];

  // Write the selected register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        smbf_pkg::REG_EXTERNAL_SEED: cfg.external_seed <= pwdata[0];
        smbf_pkg::REG_RESEED_VALUE:  cfg.reseed_value  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      smbf_pkg::REG_EXTERNAL_SEED: prdata = {63'b0, cfg.external_seed};
      smbf_pkg::REG_RESEED_VALUE:  prdata = cfg.reseed_value;
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> src/smbf_dp.sv
module smbf_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  smbf_pkg::cfg_t       cfg,
  input  smbf_pkg::cmd_t       cmd,
  output smbf_pkg::sts_t       sts,
  input  logic                 mode,
  input  logic [31:0]          length,
  input  logic [63:0]          seed_word,
  smbf_out_if.source           words
);

  logic [63:0] gen_state;
  logic [31:0] bytes_remaining;
  logic [31:0] chunk_left;
  logic [3:0]  k_reg;
  logic        took_reg;
  logic        last_reg;
  logic [63:0] z;
  logic [63:0] acc;

  logic        boundary;
  logic        rv_small;
  logic        rv_le8;
  logic        rv_lt_br;
  logic        br_lt8;
  logic [31:0] ext_chunk;
  logic [31:0] chunk_b;
  logic [31:0] chunk_c;
  logic        full;
  logic        direct;
  logic        mix;
  logic [3:0]  k_next;
  logic        took_next;
  logic [63:0] gen_b;
  logic [63:0] gen_inc;
  logic [31:0] br_next;

  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] cross_sum;

  // Work out the chunk and the word size for a next word
  always_comb begin
    boundary  = (chunk_left == '0);
    rv_small  = cfg.reseed_value < smbf_pkg::WORD_BYTES64;
    rv_le8    = cfg.reseed_value <= smbf_pkg::WORD_BYTES64;
    rv_lt_br  = cfg.reseed_value < {32'b0, bytes_remaining};
    br_lt8    = bytes_remaining < smbf_pkg::WORD_BYTES32;
    if (rv_small) begin
      ext_chunk = br_lt8 ? bytes_remaining : smbf_pkg::WORD_BYTES32;
    end else begin
      ext_chunk = rv_lt_br ? cfg.reseed_value[31:0] : bytes_remaining;
    end
    if (boundary) begin
      chunk_b = cfg.external_seed ? ext_chunk : bytes_remaining;
    end else begin
      chunk_b = chunk_left;
    end
    chunk_c   = (chunk_b > bytes_remaining) ? bytes_remaining : chunk_b;
    full      = chunk_c >= smbf_pkg::WORD_BYTES32;
    direct    = cfg.external_seed && rv_le8;
    mix       = full && !direct;
    k_next    = full ? smbf_pkg::WORD_BYTES4 : chunk_c[3:0];
    took_next = boundary && cfg.external_seed;
    gen_b     = took_next ? seed_word : gen_state;
    gen_inc   = gen_b + smbf_pkg::GOLDEN_INC;
    br_next   = bytes_remaining - {28'b0, k_next};
  end

  assign sts.productive = (mode == smbf_pkg::MODE_NEXT) && (bytes_remaining != '0);
  assign sts.mix        = mix;
  assign sts.out_free   = !words.valid || words.ready;

  // Pick the partial product for the shared 32x32 multiplier
  always_comb begin
    mul_const = cmd.mul_pass2 ? smbf_pkg::MIX_MUL2 : smbf_pkg::MIX_MUL1;
    unique case (cmd.mul_step)
      smbf_pkg::MS_LL: begin
        mul_a = z[31:0];
        mul_b = mul_const[31:0];
      end
      smbf_pkg::MS_HL: begin
        mul_a = z[63:32];
        mul_b = mul_const[31:0];
      end
      smbf_pkg::MS_LH: begin
        mul_a = z[31:0];
        mul_b = mul_const[63:32];
      end
      default: begin
        mul_a = z[31:0];
        mul_b = mul_const[31:0];
      end
    endcase
  end

  assign prod      = {32'b0, mul_a} * {32'b0, mul_b};
  assign cross_sum = acc + {prod[31:0], 32'b0};

  // Generator state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state       <= '0;
      bytes_remaining <= '0;
      chunk_left      <= '0;
      words.valid     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (mode == smbf_pkg::MODE_BEGIN) begin
          bytes_remaining <= length;
          if (cfg.external_seed) begin
            chunk_left <= '0;
          end else begin
            gen_state  <= cfg.reseed_value;
            chunk_left <= length;
          end
        end else if (bytes_remaining != '0) begin
          gen_state       <= mix ? gen_inc : gen_b;
          chunk_left      <= chunk_c - {28'b0, k_next};
          bytes_remaining <= br_next;
        end
      end
      if (cmd.emit_raw || cmd.emit_mix) begin
        words.valid <= 1'b1;
      end else if (words.ready) begin
        words.valid <= 1'b0;
      end
    end
  end

  // Word attributes, mixer registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k_reg    <= k_next;
      took_reg <= took_next;
      last_reg <= (br_next == '0);
      z        <= gen_inc ^ (gen_inc >> smbf_pkg::MIX_SH1);
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_step)
        smbf_pkg::MS_LL: acc <= prod;
        smbf_pkg::MS_HL: acc <= cross_sum;
        smbf_pkg::MS_LH: begin
          if (!cmd.mul_pass2) begin
            z <= cross_sum ^ (cross_sum >> smbf_pkg::MIX_SH2);
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit_raw) begin
      words.data        <= smbf_pkg::low_bytes(gen_state, k_reg);
      words.valid_bytes <= k_reg;
      words.seed_taken  <= took_reg;
      words.last        <= last_reg;
    end else if (cmd.emit_mix) begin
      words.data        <= cross_sum ^ (cross_sum >> smbf_pkg::MIX_SH3);
      words.valid_bytes <= smbf_pkg::WORD_BYTES4;
      words.seed_taken  <= took_reg;
      words.last        <= last_reg;
    end
  end

endmodule

>>> src/smbf_ctrl.sv
module smbf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smbf_pkg::sts_t    sts,
  output smbf_pkg::cmd_t    cmd
);

  smbf_pkg::state_t state;
  smbf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      smbf_pkg::S_IDLE: begin
        if (in_valid && sts.productive) begin
          state_next = sts.mix ? smbf_pkg::S_M1_LL : smbf_pkg::S_EMIT;
        end
      end
      smbf_pkg::S_M1_LL: state_next = smbf_pkg::S_M1_HL;
      smbf_pkg::S_M1_HL: state_next = smbf_pkg::S_M1_LH;
      smbf_pkg::S_M1_LH: state_next = smbf_pkg::S_M2_LL;
      smbf_pkg::S_M2_LL: state_next = smbf_pkg::S_M2_HL;
      smbf_pkg::S_M2_HL: state_next = smbf_pkg::S_M2_LH;
      smbf_pkg::S_M2_LH: begin
        if (sts.out_free) begin
          state_next = smbf_pkg::S_IDLE;
        end
      end
      smbf_pkg::S_EMIT: begin
        if (sts.out_free) begin
          state_next = smbf_pkg::S_IDLE;
        end
      end
      default: state_next = smbf_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_step  = smbf_pkg::MS_LL;
    unique case (state)
      smbf_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      smbf_pkg::S_M1_LL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = smbf_pkg::MS_LL;
      end
      smbf_pkg::S_M1_HL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = smbf_pkg::MS_HL;
      end
      smbf_pkg::S_M1_LH: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = smbf_pkg::MS_LH;
      end
      smbf_pkg::S_M2_LL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_step  = smbf_pkg::MS_LL;
        cmd.mul_pass2 = 1'b1;
      end
      smbf_pkg::S_M2_HL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_step  = smbf_pkg::MS_HL;
        cmd.mul_pass2 = 1'b1;
      end
      smbf_pkg::S_M2_LH: begin
        cmd.mul_step  = smbf_pkg::MS_LH;
        cmd.mul_pass2 = 1'b1;
        cmd.emit_mix  = sts.out_free;
      end
      smbf_pkg::S_EMIT: begin
        cmd.emit_raw = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> src/splitmix_byte_filler.sv
// Channel  Dir  Payload                                    Handshake
// items    in   mode, length[31:0], seed_word[63:0]        valid/ready
// words    out  data[63:0], valid_bytes[3:0], seed_taken,  valid/ready
//               last
// apb      in   64-bit registers at 0x0 and 0x8            psel/penable, pready high
//
// A begin item, or a next item with nothing left, is taken in idle and makes no word.
// A raw word (chunk tail or direct seed copy) goes out from the emit state.
// For a mixed word, each of the two 64-bit multiplies runs
// as three passes through one shared 32x32 multiplier.
// rst is synchronous; it clears the counters, the generator and the output valid.
// A word waiting on words.ready does not block the next item; only the
// finish of the following word waits for the output register to free.
module splitmix_byte_filler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smbf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [smbf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [smbf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  smbf_in_if.sink                           items,
  smbf_out_if.source                        words
);

  smbf_pkg::cfg_t cfg;
  smbf_pkg::cmd_t cmd;
  smbf_pkg::sts_t sts;

  smbf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smbf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (items.mode),
    .length    (items.length),
    .seed_word (items.seed_word),
    .words     (words)
  );

endmodule

>>> src/smbf_checker.sv
module smbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data,
  input logic [3:0]  out_valid_bytes
);

  // Byte count of a word stays in 1..8
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_valid_bytes >= 4'd1) && (out_valid_bytes <= 4'd8))
    else $error("word byte count out of range");

  // Bytes above the valid count are zero
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_valid_bytes < 4'd8)) |-> ((out_data >> {out_valid_bytes, 3'b0}) == 64'd0))
    else $error("bytes above valid count not zero");

  // Reset drops the output word
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled word changed");

endmodule

bind splitmix_byte_filler smbf_checker u_smbf_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (words.valid),
  .out_ready       (words.ready),
  .out_data        (words.data),
  .out_valid_bytes (words.valid_bytes)
);
